@@ sv/byte_frame_builder_crc16_assert.svh @@
// Assertion macros shared by the frame builder modules.
`ifndef BYTE_FRAME_BUILDER_CRC16_ASSERT_SVH
`define BYTE_FRAME_BUILDER_CRC16_ASSERT_SVH

// Check that a condition implies a consequence in the same cycle.
`define BFB_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame builder check failed");

// Check that a condition implies a consequence in the next cycle.
`define BFB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame builder check failed");

`endif

@@ sv/bfb_pkg.sv @@
// Types, codes and the CRC byte update for the frame builder.
package bfb_pkg;

    localparam logic [15:0] CRC_SEED = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_DATA  = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_SPACE = 2'd1;
    localparam logic [1:0] ST_SEQ_ERR  = 2'd2;

    localparam logic [1:0] CFG_MAX_LEN     = 2'd0;
    localparam logic [1:0] CFG_VERSION     = 2'd1;
    localparam logic [1:0] CFG_HEAD_FIRST  = 2'd2;
    localparam logic [1:0] CFG_HEAD_SECOND = 2'd3;

    localparam logic [15:0] RST_MAX_LEN     = 16'd1024;
    localparam logic [7:0]  RST_VERSION     = 8'h01;
    localparam logic [7:0]  RST_HEAD_FIRST  = 8'hFA;
    localparam logic [7:0]  RST_HEAD_SECOND = 8'hFC;

    localparam logic [16:0] HDR_CRC_BYTES = 17'd8;

    typedef struct packed {
        logic        req_type;
        logic [7:0]  command;
        logic [15:0] payload_len;
        logic [7:0]  data_byte;
    } req_item_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        last;
        logic [15:0] frame_len;
        logic [1:0]  status;
    } res_item_t;

    typedef struct packed {
        logic [15:0] max_frame_len;
        logic [7:0]  version_byte;
        logic [7:0]  head_first;
        logic [7:0]  head_second;
    } cfg_t;

    typedef struct packed {
        logic [7:0][7:0] bytes;
        logic [2:0]      last_idx;
        logic            tail;
        logic [15:0]     frame_len;
        logic [1:0]      status;
    } burst_t;

    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

@@ sv/byte_frame_builder_crc16.sv @@
// Top level: frame builder with CRC-16/CCITT-FALSE trailer and config registers.
// An item is registered, then evaluated into the result buffer when it is free;
// its results are valid from there. One item per cycle while each item yields
// one result and results are not stalled; an item with n results (header: 6,
// header with empty payload: 8, last payload byte: 3) holds the input until done.
// Reset clears the frame state and loads the config registers with their defaults.
module byte_frame_builder_crc16
    import bfb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        item_valid,
    output logic        item_stall,
    input  req_item_t   item,
    output logic        result_valid,
    input  logic        result_stall,
    output res_item_t   result
);

    cfg_t   cfg_reg;
    burst_t burst;
    logic   burst_valid;
    logic   burst_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_frame_len <= RST_MAX_LEN;
            cfg_reg.version_byte  <= RST_VERSION;
            cfg_reg.head_first    <= RST_HEAD_FIRST;
            cfg_reg.head_second   <= RST_HEAD_SECOND;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MAX_LEN:     cfg_reg.max_frame_len <= cfg_data;
                CFG_VERSION:     cfg_reg.version_byte  <= cfg_data[7:0];
                CFG_HEAD_FIRST:  cfg_reg.head_first    <= cfg_data[7:0];
                CFG_HEAD_SECOND: cfg_reg.head_second   <= cfg_data[7:0];
                default:         cfg_reg.head_second   <= cfg_reg.head_second;
            endcase
        end
    end

    bfb_ctl u_ctl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .item        (item),
        .burst_valid (burst_valid),
        .burst_take  (burst_take),
        .burst       (burst)
    );

    bfb_ser u_ser (
        .clk          (clk),
        .rst_n        (rst_n),
        .burst_valid  (burst_valid),
        .burst_take   (burst_take),
        .burst        (burst),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

@@ sv/bfb_ctl.sv @@
// Input register, frame state and per-item result burst.
module bfb_ctl
    import bfb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      item_valid,
    output logic      item_stall,
    input  req_item_t item,
    output logic      burst_valid,
    input  logic      burst_take,
    output burst_t    burst
);

    req_item_t   item_reg;
    logic        item_vld_reg;
    logic [15:0] crc_reg, crc_next;
    logic [15:0] left_reg, left_next;
    logic [15:0] total_reg, total_next;
    logic        open_reg, open_next;

    logic [16:0] total_w;
    logic [15:0] crc_hdr;
    logic [15:0] crc_dat;

    assign item_stall  = item_vld_reg && !burst_take;
    assign burst_valid = item_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg <= 1'b0;
        end
        else if (item_valid && !item_stall)
        begin
            item_vld_reg <= 1'b1;
        end
        else if (burst_take)
        begin
            item_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            item_reg <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg   <= CRC_SEED;
            left_reg  <= '0;
            total_reg <= '0;
            open_reg  <= 1'b0;
        end
        else if (burst_take)
        begin
            crc_reg   <= crc_next;
            left_reg  <= left_next;
            total_reg <= total_next;
            open_reg  <= open_next;
        end
    end

    assign total_w = HDR_CRC_BYTES + {1'b0, item_reg.payload_len};
    assign crc_hdr = crc_fold(crc_fold(crc_fold(CRC_SEED, item_reg.command),
                                       item_reg.payload_len[15:8]),
                              item_reg.payload_len[7:0]);
    assign crc_dat = crc_fold(crc_reg, item_reg.data_byte);

    always_comb
    begin
        crc_next   = crc_reg;
        left_next  = left_reg;
        total_next = total_reg;
        open_next  = open_reg;
        burst      = '0;
        if (item_reg.req_type == REQ_START)
        begin
            if (open_reg)
            begin
                burst.status = ST_SEQ_ERR;
            end
            else if (total_w > {1'b0, cfg.max_frame_len})
            begin
                burst.status = ST_NO_SPACE;
            end
            else
            begin
                burst.bytes[0] = cfg.head_first;
                burst.bytes[1] = cfg.head_second;
                burst.bytes[2] = cfg.version_byte;
                burst.bytes[3] = item_reg.command;
                burst.bytes[4] = item_reg.payload_len[15:8];
                burst.bytes[5] = item_reg.payload_len[7:0];
                burst.status   = ST_OK;
                if (item_reg.payload_len == '0)
                begin
                    burst.bytes[6]  = crc_hdr[15:8];
                    burst.bytes[7]  = crc_hdr[7:0];
                    burst.last_idx  = 3'd7;
                    burst.tail      = 1'b1;
                    burst.frame_len = total_w[15:0];
                    total_next      = total_w[15:0];
                end
                else
                begin
                    burst.last_idx = 3'd5;
                    crc_next       = crc_hdr;
                    left_next      = item_reg.payload_len;
                    total_next     = total_w[15:0];
                    open_next      = 1'b1;
                end
            end
        end
        else
        begin
            if (!open_reg)
            begin
                burst.status = ST_SEQ_ERR;
            end
            else if (left_reg == 16'd1)
            begin
                burst.bytes[0]  = item_reg.data_byte;
                burst.bytes[1]  = crc_dat[15:8];
                burst.bytes[2]  = crc_dat[7:0];
                burst.last_idx  = 3'd2;
                burst.tail      = 1'b1;
                burst.frame_len = total_reg;
                burst.status    = ST_OK;
                crc_next        = CRC_SEED;
                left_next       = '0;
                open_next       = 1'b0;
            end
            else
            begin
                burst.bytes[0] = item_reg.data_byte;
                burst.status   = ST_OK;
                crc_next       = crc_dat;
                left_next      = left_reg - 16'd1;
            end
        end
    end

`include "byte_frame_builder_crc16_assert.svh"

    `BFB_ASSERT_SAME(a_open_has_bytes, open_reg, left_reg != '0)
    `BFB_ASSERT_SAME(a_closed_crc_seed, !open_reg, crc_reg == CRC_SEED)
    `BFB_ASSERT_NEXT(a_item_held, item_vld_reg && !burst_take, item_vld_reg)

endmodule

@@ sv/bfb_ser.sv @@
// Result buffer that plays out one burst as single result items.
module bfb_ser
    import bfb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      burst_valid,
    output logic      burst_take,
    input  burst_t    burst,
    output logic      result_valid,
    input  logic      result_stall,
    output res_item_t result
);

    burst_t     burst_reg;
    logic [2:0] idx_reg;
    logic       busy_reg;
    logic       take;
    logic       at_end;

    assign take         = busy_reg && !result_stall;
    assign at_end       = idx_reg == burst_reg.last_idx;
    assign burst_take   = burst_valid && (!busy_reg || (take && at_end));
    assign result_valid = busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (burst_take)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end
        else if (take)
        begin
            if (at_end)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                idx_reg <= idx_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (burst_take)
        begin
            burst_reg <= burst;
        end
    end

    always_comb
    begin
        result.out_byte  = burst_reg.bytes[idx_reg];
        result.last      = at_end && (burst_reg.tail || burst_reg.status != ST_OK);
        result.frame_len = (at_end && burst_reg.tail) ? burst_reg.frame_len : '0;
        result.status    = burst_reg.status;
    end

`include "byte_frame_builder_crc16_assert.svh"

    `BFB_ASSERT_SAME(a_idx_in_burst, busy_reg, idx_reg <= burst_reg.last_idx)
    `BFB_ASSERT_NEXT(a_mid_burst_stays, take && !at_end, busy_reg)
    `BFB_ASSERT_SAME(a_len_only_last, result_valid && result.frame_len != '0, result.last)

endmodule
